FILE: design/ncdf_pkg.sv
`default_nettype none
package ncdf_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int PROB_W   = 16;
  localparam int A_W      = 16;
  localparam int Z_W      = 31;
  localparam int D_W      = 32;
  localparam int W_W      = 36;
  localparam int K_W      = 6;
  localparam int R_W      = 30;
  localparam int E_W      = 31;
  localparam int T_W      = 31;
  localparam int ACC_W    = 34;
  localparam int FRAC_W   = 30;

  // Fixed-point constants, all Q.30 unless noted.
  localparam longint unsigned ONE_Q30     = 64'd1 << FRAC_W;
  localparam longint unsigned DEC9        = 64'd1000000000;
  localparam longint unsigned COEF_A1     = ((64'd254829592 << FRAC_W) + DEC9 / 2) / DEC9;
  localparam longint unsigned COEF_A2_MAG = ((64'd284496736 << FRAC_W) + DEC9 / 2) / DEC9;
  localparam longint unsigned COEF_A3     = ((64'd1421413741 << FRAC_W) + DEC9 / 2) / DEC9;
  localparam longint unsigned COEF_A4_MAG = ((64'd1453152027 << FRAC_W) + DEC9 / 2) / DEC9;
  localparam longint unsigned COEF_A5     = ((64'd1061405429 << FRAC_W) + DEC9 / 2) / DEC9;
  localparam longint unsigned COEF_P      = ((64'd3275911 << FRAC_W) + 64'd5000000) / 64'd10000000;
  localparam longint unsigned RSQRT2_Q30  = 64'd759250125;
  localparam longint unsigned LN2_Q30     = 64'd744261118;
  // Estimate of 2^(W_W-FRAC_W) / ln2; the quotient it gives is at most one low.
  localparam longint unsigned LN2_RECIP   = (64'd1 << W_W) / LN2_Q30;
  localparam int RECIP_W = 7;

  localparam int EXP_TERMS    = 12;
  localparam int EXP_ZERO_K   = 31;
  localparam int DIV_STAGES   = 8;
  localparam int DIV_STEPS    = 4;
  localparam int HORNER_STEPS = 4;

  localparam logic signed [ACC_W-1:0] HORNER_START = ACC_W'(COEF_A5);
  localparam logic signed [ACC_W-1:0] HORNER_COEF [HORNER_STEPS] = '{
    ACC_W'(64'd0 - COEF_A4_MAG),
    ACC_W'(COEF_A3),
    ACC_W'(64'd0 - COEF_A2_MAG),
    ACC_W'(COEF_A1)
  };

  typedef struct packed {
    logic           neg;
    logic [D_W-1:0] d;
    logic [W_W-1:0] w;
  } front_t;

  typedef struct packed {
    logic           neg;
    logic [W_W-1:0] w;
    logic [T_W-1:0] t;
  } recip_t;

  typedef struct packed {
    logic           neg;
    logic [T_W-1:0] t;
    logic [E_W-1:0] e;
  } expo_t;

endpackage
`default_nettype wire

FILE: design/ncdf_front.sv
`default_nettype none
module ncdf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [ncdf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                valid_o,
  output ncdf_pkg::front_t                    data_o
);
  import ncdf_pkg::*;

  localparam int ZP_W = A_W + 30;
  localparam int PZ_W = 29 + Z_W;
  localparam int ZZ_W = 2 * Z_W;
  localparam logic [29:0] Rsqrt2 = 30'(RSQRT2_Q30);
  localparam logic [28:0] CoefP  = 29'(COEF_P);

  logic            valid1_q, valid2_q, valid3_q, valid4_q;
  logic            neg1_q, neg2_q, neg3_q, neg4_q;
  logic [A_W-1:0]  abs1_q, abs1_d;
  logic [ZP_W-1:0] zprod;
  logic [Z_W-1:0]  z2_q, z2_d;
  logic [PZ_W-1:0] pz3_q, pz3_d;
  logic [ZZ_W-1:0] zz3_q, zz3_d;
  logic [D_W-1:0]  d4_q, d4_d;
  logic [W_W-1:0]  w4_q, w4_d;

  always_comb begin
    abs1_d = sample_i[SAMPLE_W-1] ? A_W'(-sample_i) : A_W'(sample_i);
    zprod  = ZP_W'(abs1_q) * ZP_W'(Rsqrt2);
    z2_d   = Z_W'((zprod + ZP_W'(1 << 13)) >> 14);
    pz3_d  = PZ_W'(z2_q) * PZ_W'(CoefP);
    zz3_d  = ZZ_W'(z2_q) * ZZ_W'(z2_q);
    d4_d   = D_W'(ONE_Q30) + D_W'((pz3_q + PZ_W'(1 << 27)) >> 28);
    w4_d   = W_W'((zz3_q + ZZ_W'(1 << 25)) >> 26);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= sample_i[SAMPLE_W-1];
      abs1_q <= abs1_d;
      neg2_q <= neg1_q;
      z2_q   <= z2_d;
      neg3_q <= neg2_q;
      pz3_q  <= pz3_d;
      zz3_q  <= zz3_d;
      neg4_q <= neg3_q;
      d4_q   <= d4_d;
      w4_q   <= w4_d;
    end
  end

  always_comb begin
    valid_o     = valid4_q;
    data_o.neg  = neg4_q;
    data_o.d    = d4_q;
    data_o.w    = w4_q;
  end

endmodule
`default_nettype wire

FILE: design/ncdf_recip.sv
`default_nettype none
module ncdf_recip (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ncdf_pkg::front_t data_i,
  output logic             valid_o,
  output ncdf_pkg::recip_t data_o
);
  import ncdf_pkg::*;

  typedef struct packed {
    logic           neg;
    logic [W_W-1:0] w;
    logic [D_W-1:0] d;
    logic [D_W-1:0] rem;
    logic [D_W-1:0] num;
    logic [D_W-1:0] quo;
  } div_t;

  // The dividend is 2^60 + d/2; its top part is folded into the starting remainder.
  localparam logic [D_W-1:0] RemStart = D_W'(ONE_Q30 >> 2);

  function automatic div_t div_step(div_t x);
    div_t         y;
    logic [D_W:0] trial;
    y = x;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {y.rem, y.num[D_W-1]};
      y.num = {y.num[D_W-2:0], 1'b0};
      if (trial >= {1'b0, y.d}) begin
        y.rem = D_W'(trial - {1'b0, y.d});
        y.quo = {y.quo[D_W-2:0], 1'b1};
      end else begin
        y.rem = D_W'(trial);
        y.quo = {y.quo[D_W-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  div_t                  div_in;
  div_t                  stage_q [DIV_STAGES];
  div_t                  stage_d [DIV_STAGES];
  logic [DIV_STAGES-1:0] valid_q;

  always_comb begin
    div_in.neg = data_i.neg;
    div_in.w   = data_i.w;
    div_in.d   = data_i.d;
    div_in.rem = RemStart;
    div_in.num = {1'b0, data_i.d[D_W-1:1]};
    div_in.quo = '0;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    if (g == 0) begin : g_first
      assign stage_d[g] = div_step(div_in);
    end else begin : g_next
      assign stage_d[g] = div_step(stage_q[g-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        stage_q[i] <= stage_d[i];
      end
    end
  end

  always_comb begin
    valid_o    = valid_q[DIV_STAGES-1];
    data_o.neg = stage_q[DIV_STAGES-1].neg;
    data_o.w   = stage_q[DIV_STAGES-1].w;
    data_o.t   = T_W'(stage_q[DIV_STAGES-1].quo);
  end

endmodule
`default_nettype wire

FILE: design/ncdf_exp.sv
`default_nettype none
module ncdf_exp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ncdf_pkg::recip_t data_i,
  output logic             valid_o,
  output ncdf_pkg::expo_t  data_o
);
  import ncdf_pkg::*;

  localparam int Y_W        = 31;
  localparam int P_W        = 63;
  localparam int M_W        = 32;
  localparam int KP_W       = W_W + RECIP_W;
  localparam int SER_STAGES = 4 * EXP_TERMS;
  localparam int LAT        = SER_STAGES + 4;
  localparam logic [RECIP_W-1:0] Ln2Recip = RECIP_W'(LN2_RECIP);
  localparam logic [R_W-1:0]     Ln2      = R_W'(LN2_Q30);

  typedef struct packed {
    logic           neg;
    logic [T_W-1:0] t;
    logic [K_W-1:0] k;
    logic [R_W-1:0] r;
    logic [E_W-1:0] e;
    logic [Y_W-1:0] y;
    logic [P_W-1:0] p;
  } ser_t;

  logic [LAT-1:0]  valid_q;
  logic            neg1_q, neg2_q, neg3_q, neg4_q;
  logic [T_W-1:0]  t1_q, t2_q, t3_q, t4_q;
  logic [W_W-1:0]  w1_q;
  logic [KP_W-1:0] kp1_q, kp1_d;
  logic [K_W-1:0]  k2_q, k2_d, k3_q, k3_d;
  logic [R_W:0]    r2_q, r2_d;
  logic [R_W-1:0]  r3_q, r3_d;
  logic [E_W-1:0]  e4_q, e4_d;
  logic [E_W:0]    bias, sum;
  ser_t            ser_in;
  ser_t            ser_q [SER_STAGES];
  ser_t            ser_d [SER_STAGES];
  ser_t            ser_last;

  // Range reduction: w = k*ln2 + r with 0 <= r < ln2.
  always_comb begin
    kp1_d = KP_W'(data_i.w) * KP_W'(Ln2Recip);
    k2_d  = K_W'(kp1_q >> W_W);
    r2_d  = (R_W+1)'(w1_q - W_W'(k2_d) * W_W'(Ln2));
    if (r2_q >= (R_W+1)'(Ln2)) begin
      k3_d = k2_q + 1'b1;
      r3_d = R_W'(r2_q - (R_W+1)'(Ln2));
    end else begin
      k3_d = k2_q;
      r3_d = R_W'(r2_q);
    end
  end

  always_comb begin
    ser_in.neg = neg3_q;
    ser_in.t   = t3_q;
    ser_in.k   = k3_q;
    ser_in.r   = r3_q;
    ser_in.e   = E_W'(ONE_Q30);
    ser_in.y   = '0;
    ser_in.p   = '0;
  end

  // Each series term takes four stages: product, rounding, reciprocal multiply
  // for the division by n, then the quotient correction and the update of e.
  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int StepN = EXP_TERMS - j;
    localparam int Base  = 4 * j;
    localparam logic [P_W-1:0] HalfN = P_W'(StepN) << (FRAC_W - 1);
    localparam logic [M_W-1:0] MulN  = M_W'(64'hFFFF_FFFF / StepN);

    ser_t           src;
    logic [Y_W-1:0] quo_est;
    logic [Y_W-1:0] rem;
    logic [Y_W-1:0] quo;

    if (j == 0) begin : g_first
      assign src = ser_in;
    end else begin : g_next
      assign src = ser_q[Base-1];
    end

    always_comb begin
      ser_d[Base]   = src;
      ser_d[Base].p = P_W'(src.r) * P_W'(src.e);
    end

    always_comb begin
      ser_d[Base+1]   = ser_q[Base];
      ser_d[Base+1].y = Y_W'((ser_q[Base].p + HalfN) >> FRAC_W);
    end

    always_comb begin
      ser_d[Base+2]   = ser_q[Base+1];
      ser_d[Base+2].p = P_W'(ser_q[Base+1].y) * P_W'(MulN);
    end

    always_comb begin
      quo_est = Y_W'(ser_q[Base+2].p >> M_W);
      rem     = ser_q[Base+2].y - Y_W'(quo_est * Y_W'(StepN));
      quo     = (rem >= Y_W'(StepN)) ? quo_est + 1'b1 : quo_est;
      ser_d[Base+3]   = ser_q[Base+2];
      ser_d[Base+3].e = E_W'(ONE_Q30) - E_W'(quo);
    end
  end

  // Scale by 2^-k with rounding; the term vanishes for large k.
  always_comb begin
    ser_last = ser_q[SER_STAGES-1];
    bias     = ((E_W+1)'(1) << ser_last.k) >> 1;
    sum      = {1'b0, ser_last.e} + bias;
    if (ser_last.k >= K_W'(EXP_ZERO_K)) begin
      e4_d = '0;
    end else begin
      e4_d = E_W'(sum >> ser_last.k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= data_i.neg;
      t1_q   <= data_i.t;
      w1_q   <= data_i.w;
      kp1_q  <= kp1_d;
      neg2_q <= neg1_q;
      t2_q   <= t1_q;
      k2_q   <= k2_d;
      r2_q   <= r2_d;
      neg3_q <= neg2_q;
      t3_q   <= t2_q;
      k3_q   <= k3_d;
      r3_q   <= r3_d;
      for (int i = 0; i < SER_STAGES; i++) begin
        ser_q[i] <= ser_d[i];
      end
      neg4_q <= ser_last.neg;
      t4_q   <= ser_last.t;
      e4_q   <= e4_d;
    end
  end

  always_comb begin
    valid_o    = valid_q[LAT-1];
    data_o.neg = neg4_q;
    data_o.t   = t4_q;
    data_o.e   = e4_q;
  end

endmodule
`default_nettype wire

FILE: design/ncdf_poly.sv
`default_nettype none
module ncdf_poly (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  ncdf_pkg::expo_t             data_i,
  output logic                        valid_o,
  output logic [ncdf_pkg::PROB_W-1:0] probability_o
);
  import ncdf_pkg::*;

  localparam int MAG_W      = ACC_W - 1;
  localparam int PR_W       = 65;
  localparam int Q_W        = 34;
  localparam int C_W        = PR_W - FRAC_W;
  localparam int HOR_STAGES = 2 * HORNER_STEPS;
  localparam int LAT        = HOR_STAGES + 4;

  typedef struct packed {
    logic                    neg;
    logic [T_W-1:0]          t;
    logic [E_W-1:0]          e;
    logic signed [ACC_W-1:0] acc;
    logic                    pneg;
    logic [PR_W-1:0]         prod;
  } hor_t;

  logic [LAT-1:0]    valid_q;
  hor_t              hor_in;
  hor_t              hor_q [HOR_STAGES];
  hor_t              hor_d [HOR_STAGES];
  hor_t              hor_last;
  logic [MAG_W-1:0]  clamp;
  logic              neg1_q, neg2_q, neg3_q;
  logic [E_W-1:0]    e1_q, e2_q;
  logic [PR_W-1:0]   prod1_q, prod1_d;
  logic [Q_W-1:0]    q2_q, q2_d;
  logic [PR_W-1:0]   prod3_q, prod3_d;
  logic [C_W-1:0]    c_full;
  logic [FRAC_W:0]   c_lim;
  logic [PROB_W-1:0] half;
  logic [PROB_W-1:0] prob_q, prob_d;

  always_comb begin
    hor_in.neg  = data_i.neg;
    hor_in.t    = data_i.t;
    hor_in.e    = data_i.e;
    hor_in.acc  = HORNER_START;
    hor_in.pneg = 1'b0;
    hor_in.prod = '0;
  end

  // Horner in signed Q.30: magnitude times t, then rounding, sign and coefficient.
  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    hor_t              src;
    logic [MAG_W-1:0]  mag;
    logic [ACC_W-1:0]  rnd;

    if (j == 0) begin : g_first
      assign src = hor_in;
    end else begin : g_next
      assign src = hor_q[2*j-1];
    end

    always_comb begin
      mag = MAG_W'(src.acc[ACC_W-1] ? -src.acc : src.acc);
      hor_d[2*j]      = src;
      hor_d[2*j].pneg = src.acc[ACC_W-1];
      hor_d[2*j].prod = PR_W'(mag) * PR_W'(src.t);
    end

    always_comb begin
      rnd = ACC_W'((hor_q[2*j].prod + PR_W'(1 << (FRAC_W - 1))) >> FRAC_W);
      hor_d[2*j+1]     = hor_q[2*j];
      hor_d[2*j+1].acc = (hor_q[2*j].pneg ? -$signed(rnd) : $signed(rnd)) + HORNER_COEF[j];
    end
  end

  always_comb begin
    hor_last = hor_q[HOR_STAGES-1];
    clamp    = hor_last.acc[ACC_W-1] ? '0 : MAG_W'(hor_last.acc);
    prod1_d  = PR_W'(clamp) * PR_W'(hor_last.t);
    q2_d     = Q_W'((prod1_q + PR_W'(1 << (FRAC_W - 1))) >> FRAC_W);
    prod3_d  = PR_W'(q2_q) * PR_W'(e2_q);
    c_full   = C_W'((prod3_q + PR_W'(1 << (FRAC_W - 1))) >> FRAC_W);
    c_lim    = (c_full > C_W'(ONE_Q30)) ? (FRAC_W+1)'(ONE_Q30) : (FRAC_W+1)'(c_full);
    half     = PROB_W'((c_lim + (FRAC_W+1)'(1 << 14)) >> 15);
    if (neg3_q) begin
      prob_d = half;
    end else if (half == '0) begin
      prob_d = '1;
    end else begin
      prob_d = PROB_W'((PROB_W+1)'(1 << PROB_W) - (PROB_W+1)'(half));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < HOR_STAGES; i++) begin
        hor_q[i] <= hor_d[i];
      end
      neg1_q  <= hor_last.neg;
      e1_q    <= hor_last.e;
      prod1_q <= prod1_d;
      neg2_q  <= neg1_q;
      e2_q    <= e1_q;
      q2_q    <= q2_d;
      neg3_q  <= neg2_q;
      prod3_q <= prod3_d;
      prob_q  <= prob_d;
    end
  end

  assign valid_o       = valid_q[LAT-1];
  assign probability_o = prob_q;

endmodule
`default_nettype wire

FILE: design/normal_cdf_approximation.sv
// Standard normal CDF, one sample per request.
//
// Input channel: valid_i, stall_o and sample_i, a signed Q4.12 value. A request
// is taken at a rising edge where valid_i is high and stall_o is low.
// Output channel: valid_o, stall_i and probability_o, the cumulative probability
// in unsigned Q0.16, saturated to 65535. A result is delivered at an edge where
// valid_o is high and stall_i is low.
//
// The pipeline takes a new request every cycle while stall_o is low. Each result
// passes through |x|, z, p*z and z^2; the restoring divider that
// forms t = 1/(1+p*z) four bits per stage; the range reduction and the
// twelve-term series of exp(-z^2), four stages per term; then the Horner
// polynomial and the final products, the last stage being the output register.
//
// Reset clears every valid bit, so the pipeline comes up empty. When a result
// waits with stall_i high, the whole pipeline freezes and stall_o goes high;
// no request is lost or repeated, and the waiting result holds still.
`default_nettype none
module normal_cdf_approximation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 stall_o,
  input  logic signed [ncdf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic [ncdf_pkg::PROB_W-1:0]          probability_o
);
  import ncdf_pkg::*;

  // All stages move together unless a finished result is being held back.
  logic   advance;
  logic   front_valid, recip_valid, expo_valid;
  front_t front_data;
  recip_t recip_data;
  expo_t  expo_data;

  assign advance = !(valid_o && stall_i);
  assign stall_o = !advance;

  ncdf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .valid_i  (valid_i),
    .sample_i (sample_i),
    .valid_o  (front_valid),
    .data_o   (front_data)
  );

  ncdf_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (recip_valid),
    .data_o  (recip_data)
  );

  ncdf_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (recip_valid),
    .data_i  (recip_data),
    .valid_o (expo_valid),
    .data_o  (expo_data)
  );

  ncdf_poly u_poly (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .valid_i       (expo_valid),
    .data_i        (expo_data),
    .valid_o       (valid_o),
    .probability_o (probability_o)
  );

endmodule
`default_nettype wire
